>>> src/bblc_pkg.sv
// Package: widths, operation codes, sequencer states and shared types of the byte budget LRU cache.
package bblc_pkg;

  localparam int unsigned Entries    = 64;
  localparam int unsigned IdxBits    = $clog2(Entries);
  localparam int unsigned CntBits    = $clog2(Entries + 1);
  localparam int unsigned KeyBits    = 64;
  localparam int unsigned HandleBits = 32;
  localparam int unsigned LenBits    = 16;
  localparam int unsigned ChargeBits = LenBits + 1;
  localparam int unsigned UsedBits   = 33;
  localparam int unsigned CapBits    = 32;
  localparam int unsigned CapReset   = 65536;
  localparam int unsigned MinCharge  = 2;
  // key, handle, has_value, charge, prev, next
  localparam int unsigned EntBits    = KeyBits + HandleBits + 1 + ChargeBits + 2 * IdxBits;

  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_PUT    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_MISS     = 2'd1,
    ST_OVERSIZE = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FOUND,
    S_DET_RD,
    S_DET_CAP,
    S_DET_A,
    S_DET_RN,
    S_DET_B,
    S_DET_DONE,
    S_EVICT_CHK,
    S_FREE_SCAN,
    S_PUSH_RD,
    S_PUSH_A,
    S_PUSH_B,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [KeyBits-1:0]    key;
    logic [HandleBits-1:0] handle;
    logic                  has_value;
    logic [ChargeBits-1:0] charge;
    logic [IdxBits-1:0]    prev;
    logic [IdxBits-1:0]    next;
  } entry_t;

  typedef struct packed {
    logic [1:0]            func;
    logic [KeyBits-1:0]    key_tag;
    logic [LenBits-1:0]    key_len;
    logic [HandleBits-1:0] value_handle;
    logic                  value_present;
    logic [LenBits-1:0]    value_len;
  } req_t;

  typedef struct packed {
    logic                  hit;
    logic [HandleBits-1:0] out_handle;
    logic                  out_present;
    logic [1:0]            status;
    logic [31:0]           bytes_used;
  } rsp_t;

endpackage

>>> src/bblc_if.sv
// Interfaces: valid/ready channels for request and result beats.
interface bblc_req_if;
  logic          valid;
  logic          ready;
  bblc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface bblc_rsp_if;
  logic          valid;
  logic          ready;
  bblc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/bblc_ram.sv
// Generic single-port RAM with registered read.
module bblc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

>>> src/byte_budget_lru_cache.sv
// Top level: sequencer of the byte budget LRU cache around one entry RAM.
//
// Channel   Dir  Beat contents
// req_if    in   func, key_tag, key_len, value_handle, value_present, value_len
// rsp_if    out  hit, out_handle, out_present, status, bytes_used
// cfg       in   cfg_we_i / cfg_wdata_i write capacity_bytes
//
// One beat at a time goes through a sequencer that drives a single RAM port.
// The key search reads and checks the slots in order (read, then check). An
// unlink reads and rewrites the previous, then the next neighbour and updates
// the ends; an eviction is a budget check, read and capture of the least recent
// slot, then an unlink; the free-slot search checks one slot per cycle, and
// linking at the front reads and rewrites the old front, then writes the new entry.
// Reset clears valid bits, pointers, count and byte total at once; no sweep.
// A result waits in its output register until taken; no request is accepted
// meanwhile.
module byte_budget_lru_cache (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bblc_pkg::CapBits-1:0]  cfg_wdata_i,
  bblc_req_if.sink                      req_if,
  bblc_rsp_if.source                    rsp_if
);
  localparam int unsigned IB = bblc_pkg::IdxBits;

  bblc_pkg::state_e state_q, state_d;
  bblc_pkg::req_t   req_q;
  logic [bblc_pkg::CapBits-1:0]  cap_q;
  logic [bblc_pkg::Entries-1:0]  valid_q;
  logic [IB-1:0]                 mru_q, lru_q, ptr_q, tgt_q;
  logic [bblc_pkg::CntBits-1:0]  cnt_q;
  logic [bblc_pkg::UsedBits-1:0] used_q;
  logic [bblc_pkg::ChargeBits-1:0] charge_q;
  bblc_pkg::entry_t              ent_q;   // entry being detached
  bblc_pkg::rsp_t                rsp_q;
  logic                          rsp_v_q;

  logic                  we;
  logic [IB-1:0]         addr;
  bblc_pkg::entry_t      wdata, rdata;

  bblc_ram #(.Width(bblc_pkg::EntBits), .Depth(bblc_pkg::Entries)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  logic [bblc_pkg::ChargeBits-1:0] charge_raw;
  logic [bblc_pkg::UsedBits-1:0]   need;
  logic                            last_slot;
  logic                            oversize;

  assign charge_raw = {1'b0, req_if.data.key_len}
                    + (req_if.data.value_present ? {1'b0, req_if.data.value_len} : '0);
  assign need       = used_q + {{(bblc_pkg::UsedBits-bblc_pkg::ChargeBits){1'b0}}, charge_q};
  assign last_slot  = (ptr_q == IB'(bblc_pkg::Entries - 1));
  assign oversize   = (bblc_pkg::CapBits'(charge_q) > cap_q);

  assign req_if.ready = (state_q == bblc_pkg::S_IDLE) && !rsp_v_q;
  assign rsp_if.valid = rsp_v_q;
  assign rsp_if.data  = rsp_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bblc_pkg::S_IDLE: begin
        if (req_if.valid && req_if.ready) begin
          state_d = (req_if.data.func == bblc_pkg::FUNC_CLEAR) ? bblc_pkg::S_OUT
                                                                : bblc_pkg::S_SCAN_RD;
        end
      end
      bblc_pkg::S_SCAN_RD:  state_d = bblc_pkg::S_SCAN_CHK;
      bblc_pkg::S_SCAN_CHK: begin
        if (valid_q[ptr_q] && rdata.key == req_q.key_tag) state_d = bblc_pkg::S_FOUND;
        else if (!last_slot) state_d = bblc_pkg::S_SCAN_RD;
        else if (req_q.func == bblc_pkg::FUNC_PUT) state_d = bblc_pkg::S_EVICT_CHK;
        else state_d = bblc_pkg::S_OUT;
      end
      bblc_pkg::S_FOUND:    state_d = bblc_pkg::S_DET_A;
      bblc_pkg::S_DET_RD:   state_d = bblc_pkg::S_DET_CAP;
      bblc_pkg::S_DET_CAP:  state_d = bblc_pkg::S_FOUND;
      bblc_pkg::S_DET_A:    state_d = bblc_pkg::S_DET_RN;
      bblc_pkg::S_DET_RN:   state_d = bblc_pkg::S_DET_B;
      bblc_pkg::S_DET_B:    state_d = bblc_pkg::S_DET_DONE;
      bblc_pkg::S_DET_DONE: begin
        if (req_q.func == bblc_pkg::FUNC_GET) state_d = bblc_pkg::S_PUSH_RD;
        else if (req_q.func == bblc_pkg::FUNC_PUT) state_d = bblc_pkg::S_EVICT_CHK;
        else state_d = bblc_pkg::S_OUT;
      end
      bblc_pkg::S_EVICT_CHK: begin
        if (oversize) state_d = bblc_pkg::S_OUT;
        else if (cnt_q != '0 && (need > {1'b0, cap_q}
                 || cnt_q >= bblc_pkg::CntBits'(bblc_pkg::Entries)))
          state_d = bblc_pkg::S_DET_RD;
        else state_d = bblc_pkg::S_FREE_SCAN;
      end
      bblc_pkg::S_FREE_SCAN: begin
        if (!valid_q[ptr_q]) state_d = bblc_pkg::S_PUSH_RD;
      end
      bblc_pkg::S_PUSH_RD:  state_d = bblc_pkg::S_PUSH_A;
      bblc_pkg::S_PUSH_A:   state_d = bblc_pkg::S_PUSH_B;
      bblc_pkg::S_PUSH_B:   state_d = bblc_pkg::S_OUT;
      bblc_pkg::S_OUT:      state_d = bblc_pkg::S_IDLE;
      default:              state_d = bblc_pkg::S_IDLE;
    endcase
  end

  // RAM port control. Every neighbour update is a read-modify-write: the
  // state before issues the read, so rdata holds that neighbour when it is
  // written back.
  always_comb begin
    we    = 1'b0;
    addr  = ptr_q;
    wdata = rdata;
    unique case (state_q)
      bblc_pkg::S_DET_RD:  addr = lru_q;
      bblc_pkg::S_FOUND:   addr = ent_q.prev;
      bblc_pkg::S_DET_A: begin
        addr = ent_q.prev;
        if (cnt_q > bblc_pkg::CntBits'(1) && tgt_q != mru_q) begin
          we = 1'b1;
          wdata.next = ent_q.next;
        end
      end
      bblc_pkg::S_DET_RN:  addr = ent_q.next;
      bblc_pkg::S_DET_B: begin
        addr = ent_q.next;
        if (cnt_q > bblc_pkg::CntBits'(1) && tgt_q != lru_q) begin
          we = 1'b1;
          wdata.prev = ent_q.prev;
        end
      end
      bblc_pkg::S_PUSH_RD: addr = mru_q;
      bblc_pkg::S_PUSH_A: begin
        addr = mru_q;
        if (cnt_q != '0) begin
          we = 1'b1;
          wdata.prev = tgt_q;
        end
      end
      bblc_pkg::S_PUSH_B: begin
        addr = tgt_q;
        we   = 1'b1;
        if (req_q.func == bblc_pkg::FUNC_GET) begin
          wdata = ent_q;
        end else begin
          wdata.key       = req_q.key_tag;
          wdata.handle    = req_q.value_handle;
          wdata.has_value = req_q.value_present;
          wdata.charge    = charge_q;
          wdata.next      = ent_q.next;
        end
        wdata.prev = tgt_q;
        if (cnt_q != '0) wdata.next = mru_q;
      end
      default: ;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bblc_pkg::S_IDLE;
      cap_q   <= bblc_pkg::CapBits'(bblc_pkg::CapReset);
      valid_q <= '0;
      mru_q   <= '0;
      lru_q   <= '0;
      cnt_q   <= '0;
      used_q  <= '0;
      rsp_v_q <= 1'b0;
      ptr_q   <= '0;
      tgt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (rsp_v_q && rsp_if.ready) rsp_v_q <= 1'b0;
      unique case (state_q)
        bblc_pkg::S_IDLE: begin
          ptr_q <= '0;
          if (req_if.valid && req_if.ready) begin
            req_q    <= req_if.data;
            charge_q <= (charge_raw < bblc_pkg::ChargeBits'(bblc_pkg::MinCharge))
                        ? bblc_pkg::ChargeBits'(bblc_pkg::MinCharge) : charge_raw;
            rsp_q.hit        <= 1'b0;
            rsp_q.status     <= bblc_pkg::ST_DONE;
            rsp_q.bytes_used <= '0;
            if (req_if.data.func == bblc_pkg::FUNC_PUT) begin
              rsp_q.out_handle  <= req_if.data.value_handle;
              rsp_q.out_present <= req_if.data.value_present;
            end else begin
              rsp_q.out_handle  <= '0;
              rsp_q.out_present <= 1'b0;
            end
            if (req_if.data.func == bblc_pkg::FUNC_CLEAR) begin
              valid_q <= '0;
              cnt_q   <= '0;
              used_q  <= '0;
              mru_q   <= '0;
              lru_q   <= '0;
            end
          end
        end
        bblc_pkg::S_SCAN_CHK: begin
          if (valid_q[ptr_q] && rdata.key == req_q.key_tag) begin
            tgt_q <= ptr_q;
            ent_q <= rdata;
            if (req_q.func == bblc_pkg::FUNC_GET) begin
              rsp_q.hit         <= 1'b1;
              rsp_q.out_handle  <= rdata.handle;
              rsp_q.out_present <= rdata.has_value;
            end
          end else begin
            if (last_slot && req_q.func == bblc_pkg::FUNC_GET) begin
              rsp_q.status <= bblc_pkg::ST_MISS;
            end
            ptr_q <= ptr_q + IB'(1);
          end
        end
        bblc_pkg::S_DET_RD: begin
          tgt_q <= lru_q;
        end
        bblc_pkg::S_DET_CAP: begin
          ent_q <= rdata;
        end
        bblc_pkg::S_DET_DONE: begin
          if (cnt_q <= bblc_pkg::CntBits'(1)) begin
            mru_q <= '0;
            lru_q <= '0;
          end else begin
            if (tgt_q == mru_q) mru_q <= ent_q.next;
            if (tgt_q == lru_q) lru_q <= ent_q.prev;
          end
          cnt_q <= cnt_q - bblc_pkg::CntBits'(1);
          if (req_q.func != bblc_pkg::FUNC_GET) begin
            valid_q[tgt_q] <= 1'b0;
            used_q <= (used_q >= {16'd0, ent_q.charge})
                      ? used_q - {16'd0, ent_q.charge} : '0;
          end
          ptr_q <= '0;
        end
        bblc_pkg::S_EVICT_CHK: begin
          ptr_q <= '0;
          if (oversize) begin
            valid_q      <= '0;
            cnt_q        <= '0;
            used_q       <= '0;
            mru_q        <= '0;
            lru_q        <= '0;
            rsp_q.status <= bblc_pkg::ST_OVERSIZE;
          end
        end
        bblc_pkg::S_FREE_SCAN: begin
          if (!valid_q[ptr_q]) tgt_q <= ptr_q;
          else ptr_q <= ptr_q + IB'(1);
        end
        bblc_pkg::S_PUSH_B: begin
          if (cnt_q == '0) lru_q <= tgt_q;
          mru_q          <= tgt_q;
          cnt_q          <= cnt_q + bblc_pkg::CntBits'(1);
          valid_q[tgt_q] <= 1'b1;
          if (req_q.func == bblc_pkg::FUNC_PUT) begin
            used_q <= need;
          end
        end
        bblc_pkg::S_OUT: begin
          rsp_q.bytes_used <= used_q[31:0];
          rsp_v_q          <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule
